[sv/periodic_task_scheduler_rm_edf_core_macros.svh]
// Assertion macros shared by the scheduler modules.
// Depends on nothing; each user supplies clk and rst in scope.
`ifndef PERIODIC_TASK_SCHEDULER_RM_EDF_CORE_MACROS_SVH
`define PERIODIC_TASK_SCHEDULER_RM_EDF_CORE_MACROS_SVH

// Check a consequence in the same cycle as its trigger.
`define PTSRE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger.
`define PTSRE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/ptsre_pkg.sv]
// Shared types, constants and helpers of the periodic task scheduler.
// Used by the register file, controller, datapath and top level.
package ptsre_pkg;

  localparam int MAX_TASKS = 4;
  localparam int TIME_BITS = 16;
  localparam int SLOT_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int FIELD_W   = 16;
  localparam int COUNT_W   = 3;
  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = 3;

  // Register indexes on the configuration port
  localparam logic [REG_IDX_W-1:0] REG_MODE  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_COUNT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_TASK0 = 3'd2;

  localparam logic MODE_RM  = 1'b0;
  localparam logic MODE_EDF = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic                           sched_mode;
    logic [COUNT_W-1:0]             task_count;
    logic [MAX_TASKS-1:0][31:0]     task_word;
  } cfg_t;

  typedef struct packed {
    logic              load;
    logic              scan;
    logic [SLOT_W-1:0] slot;
    logic              commit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

  // Period field; zero counts as one
  function automatic logic [FIELD_W-1:0] period_of(input logic [31:0] word);
    logic [FIELD_W-1:0] p;
    p = word[31:16];
    return (p == '0) ? FIELD_W'(1) : p;
  endfunction

  function automatic logic [FIELD_W-1:0] exec_of(input logic [31:0] word);
    return word[15:0];
  endfunction

endpackage

[sv/ptsre_regs.sv]
// Configuration register file behind the APB-style port.
// Depends on ptsre_pkg.
module ptsre_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ptsre_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output ptsre_pkg::cfg_t                 cfg
);

  logic [ptsre_pkg::REG_IDX_W-1:0] idx;
  logic [ptsre_pkg::REG_IDX_W-1:0] word_idx;
  logic                            wr;

  assign pready   = 1'b1;
  assign idx      = paddr[ptsre_pkg::ADDR_W-1:2];
  assign word_idx = idx - ptsre_pkg::REG_TASK0;
  assign wr       = psel && penable && pwrite;

  // Write registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sched_mode <= ptsre_pkg::MODE_RM;
      cfg.task_count <= ptsre_pkg::COUNT_W'(1);
      cfg.task_word  <= '0;
    end else if (wr) begin
      if (idx == ptsre_pkg::REG_MODE) begin
        cfg.sched_mode <= pwdata[0];
      end
      if (idx == ptsre_pkg::REG_COUNT) begin
        cfg.task_count <= pwdata[ptsre_pkg::COUNT_W-1:0];
      end
      for (int i = 0; i < ptsre_pkg::MAX_TASKS; i++) begin
        if (idx == ptsre_pkg::REG_TASK0 + ptsre_pkg::REG_IDX_W'(i)) begin
          cfg.task_word[i] <= pwdata;
        end
      end
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (idx == ptsre_pkg::REG_MODE) begin
      prdata = 32'(cfg.sched_mode);
    end else if (idx == ptsre_pkg::REG_COUNT) begin
      prdata = 32'(cfg.task_count);
    end else if (idx >= ptsre_pkg::REG_TASK0 &&
                 32'(word_idx) < ptsre_pkg::MAX_TASKS) begin
      prdata = cfg.task_word[word_idx[ptsre_pkg::SLOT_W-1:0]];
    end
  end

endmodule

[sv/ptsre_ctrl.sv]
// Tick sequencer: accepts a tick, walks the task slots, then commits.
// Depends on ptsre_pkg and the assertion macro header.
`include "periodic_task_scheduler_rm_edf_core_macros.svh"
module ptsre_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  ptsre_pkg::stat_t   stat,
  output ptsre_pkg::cmd_t    cmd
);

  localparam logic [ptsre_pkg::SLOT_W-1:0] LAST_SLOT =
    ptsre_pkg::SLOT_W'(ptsre_pkg::MAX_TASKS - 1);

  ptsre_pkg::state_t             state, state_next;
  logic [ptsre_pkg::SLOT_W-1:0]  slot, slot_next;
  logic                          accept;

  // Hold state and slot counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptsre_pkg::ST_IDLE;
      slot  <= '0;
    end else begin
      state <= state_next;
      slot  <= slot_next;
    end
  end

  // Next state and commands
  always_comb begin
    in_stall   = !((state == ptsre_pkg::ST_IDLE) ||
                   (state == ptsre_pkg::ST_COMMIT && stat.out_free));
    accept     = in_valid && !in_stall;
    state_next = state;
    slot_next  = slot;
    cmd.load   = accept;
    cmd.scan   = 1'b0;
    cmd.slot   = slot;
    cmd.commit = 1'b0;
    case (state)
      ptsre_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = ptsre_pkg::ST_SCAN;
          slot_next  = '0;
        end
      end
      ptsre_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (slot == LAST_SLOT) begin
          state_next = ptsre_pkg::ST_COMMIT;
        end else begin
          slot_next = slot + 1'b1;
        end
      end
      ptsre_pkg::ST_COMMIT: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          slot_next  = '0;
          state_next = accept ? ptsre_pkg::ST_SCAN : ptsre_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ptsre_pkg::ST_IDLE;
      end
    endcase
  end

  `PTSRE_ASSERT_NEXT(a_accept_starts_scan, in_valid && !in_stall, cmd.scan && cmd.slot == '0, "tick accepted but scan did not start at slot zero")
  `PTSRE_ASSERT_NEXT(a_last_slot_commits, cmd.scan && cmd.slot == LAST_SLOT, state == ptsre_pkg::ST_COMMIT, "scan of last slot not followed by commit")
  `PTSRE_ASSERT_NOW(a_no_accept_in_scan, state == ptsre_pkg::ST_SCAN, in_stall, "tick accepted during scan")

endmodule

[sv/ptsre_dp.sv]
// Scheduler datapath: per-slot countdown and work, best-candidate search,
// time counter and output register. Depends on ptsre_pkg and the macro header.
`include "periodic_task_scheduler_rm_edf_core_macros.svh"
module ptsre_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  ptsre_pkg::cfg_t                 cfg,
  input  ptsre_pkg::cmd_t                 cmd,
  output ptsre_pkg::stat_t                stat,
  input  logic                            restart,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            busy_res,
  output logic [1:0]                      running_task,
  output logic                            deadline_missed,
  output logic [15:0]                     tick_time
);

  localparam int FW = ptsre_pkg::FIELD_W;

  logic [FW-1:0]                     ttr  [ptsre_pkg::MAX_TASKS];
  logic [FW-1:0]                     work [ptsre_pkg::MAX_TASKS];
  logic [ptsre_pkg::TIME_BITS-1:0]   time_cnt;
  logic [ptsre_pkg::TIME_BITS-1:0]   time_now;
  logic                              restart_q;
  logic                              found;
  logic [ptsre_pkg::SLOT_W-1:0]      pick_slot;
  logic [FW-1:0]                     best_key;
  logic [FW-1:0]                     best_work;
  logic [FW-1:0]                     best_ttr;

  logic [31:0]   word;
  logic [FW-1:0] ttr_cur, ttr_rl, work_rl, period, key, work_dec;
  logic          in_use, take, missed;

  assign stat.out_free = !out_valid || !out_stall;

  // Reload and candidate test for the slot under scan
  always_comb begin
    word     = cfg.task_word[cmd.slot];
    period   = ptsre_pkg::period_of(word);
    ttr_cur  = restart_q ? '0 : ttr[cmd.slot];
    ttr_rl   = (ttr_cur == '0) ? period : ttr_cur;
    work_rl  = (ttr_cur == '0) ? ptsre_pkg::exec_of(word) : work[cmd.slot];
    in_use   = 32'(cmd.slot) < 32'(cfg.task_count);
    key      = (cfg.sched_mode == ptsre_pkg::MODE_EDF) ? ttr_rl : period;
    take     = in_use && (work_rl != '0) && (!found || key < best_key);
    work_dec = best_work - 1'b1;
    missed   = found && (work_dec != '0) && (best_ttr == FW'(1));
    time_now = restart_q ? '0 : time_cnt;
  end

  // Slot state: reload, count down, charge the chosen task
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ptsre_pkg::MAX_TASKS; i++) begin
        ttr[i]  <= '0;
        work[i] <= '0;
      end
      time_cnt <= '0;
    end else begin
      if (cmd.scan) begin
        if (in_use) begin
          ttr[cmd.slot]  <= ttr_rl - 1'b1;
          work[cmd.slot] <= work_rl;
        end else begin
          ttr[cmd.slot]  <= '0;
          work[cmd.slot] <= '0;
        end
      end
      if (cmd.commit) begin
        if (found) begin
          work[pick_slot] <= work_dec;
        end
        time_cnt <= time_now + 1'b1;
      end
    end
  end

  // Latch tick input and track the best candidate
  always_ff @(posedge clk) begin
    if (rst) begin
      found     <= 1'b0;
      restart_q <= 1'b0;
    end else begin
      if (cmd.load) begin
        restart_q <= restart;
        found     <= 1'b0;
      end else if (cmd.scan && take) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan && take) begin
      pick_slot <= cmd.slot;
      best_key  <= key;
      best_work <= work_rl;
      best_ttr  <= ttr_rl;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      busy_res        <= found;
      running_task    <= found ? 2'(pick_slot) : 2'd0;
      deadline_missed <= missed;
      tick_time       <= 16'(time_now);
    end
  end

  `PTSRE_ASSERT_NEXT(a_commit_fills_out, cmd.commit, out_valid, "commit did not fill the output register")
  `PTSRE_ASSERT_NOW(a_idle_result_clean, out_valid && !busy_res, running_task == 2'd0 && !deadline_missed, "idle tick reports a task or a miss")
  `PTSRE_ASSERT_NOW(a_commit_needs_room, cmd.commit, stat.out_free, "commit while output register is held")

endmodule

[sv/periodic_task_scheduler_rm_edf_core.sv]
// Periodic task scheduler, rate monotonic or earliest deadline first.
// Usage:
//   Tick channel (in_valid/in_stall/restart): one beat is one scheduler tick;
//   restart high makes that tick time zero and releases every task.
//   Result channel (out_valid/out_stall): one beat per tick with busy_res,
//   running_task, deadline_missed and tick_time.
//   Configuration: APB-style port, registers at byte address 4*index:
//   mode, task count, then one word per task slot. Write only when idle.
// Timing:
//   A tick walks the task slots one per cycle and then commits; the result
//   is registered at the commit. The next tick beat is taken in the commit
//   cycle, so no new tick is accepted while the slots are being scanned.
// Reset:
//   Synchronous rst clears the slot state, the time counter and the output
//   valid flag; registers return to RM mode, one task, zero task words.
// Back-pressure:
//   While out_stall holds a result, the next tick completes its scan and then
//   waits in commit, stalling the tick channel until the result is taken.
// Depends on ptsre_pkg, ptsre_regs, ptsre_ctrl and ptsre_dp.
module periodic_task_scheduler_rm_edf_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ptsre_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          restart,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          busy_res,
  output logic [1:0]                    running_task,
  output logic                          deadline_missed,
  output logic [15:0]                   tick_time
);

  ptsre_pkg::cfg_t  cfg;
  ptsre_pkg::cmd_t  cmd;
  ptsre_pkg::stat_t stat;

  ptsre_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ptsre_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ptsre_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .cmd             (cmd),
    .stat            (stat),
    .restart         (restart),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .busy_res        (busy_res),
    .running_task    (running_task),
    .deadline_missed (deadline_missed),
    .tick_time       (tick_time)
  );

endmodule

[tb/periodic_task_scheduler_rm_edf_core_tb.sv]
// Self-checking testbench for the RM/EDF periodic task scheduler core.
// Runs a directed table and random phases, with one long receiver hold-off.
// Depends on ptsre_pkg and periodic_task_scheduler_rm_edf_core.
`timescale 1ns / 100ps

module periodic_task_scheduler_rm_edf_core_tb;

  localparam int RUN_LIMIT_NS = 5_000_000;
  localparam int DRAIN_CYCLES = 12;
  localparam int LONG_HOLD    = 80;
  localparam int RAND_PHASES  = 8;
  localparam int PRINT_CAP    = 40;

  localparam logic [ptsre_pkg::REG_IDX_W-1:0] REG_TASK1 = ptsre_pkg::REG_TASK0 + 3'd1;
  localparam logic [ptsre_pkg::REG_IDX_W-1:0] REG_TASK2 = ptsre_pkg::REG_TASK0 + 3'd2;
  localparam logic [ptsre_pkg::REG_IDX_W-1:0] REG_TASK3 = ptsre_pkg::REG_TASK0 + 3'd3;
  // index past the register list: writes must be ignored
  localparam logic [ptsre_pkg::REG_IDX_W-1:0] REG_SPARE = ptsre_pkg::REG_TASK0 + 3'd4;

  typedef struct packed {
    logic        busy;
    logic [1:0]  slot;
    logic        missed;
    logic [15:0] stamp;
  } sched_out_t;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t                        kind;
    logic [ptsre_pkg::REG_IDX_W-1:0]  idx;
    logic [31:0]                      data;
    logic                             rs;
    logic                             typed;
    sched_out_t                       want;
  } dir_row_t;

  localparam sched_out_t NO_WANT = '0;
  localparam int DIR_ROWS = 29;

  logic                           clk;
  logic                           rst;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [ptsre_pkg::ADDR_W-1:0]   paddr;
  logic [31:0]                    pwdata;
  logic [31:0]                    prdata;
  logic                           pready;
  logic                           in_valid;
  logic                           in_stall;
  logic                           restart;
  logic                           out_valid;
  logic                           out_stall;
  logic                           busy_res;
  logic [1:0]                     running_task;
  logic                           deadline_missed;
  logic [15:0]                    tick_time;

  // Scheduler image: registers and per-slot state
  logic                            mode_q = ptsre_pkg::MODE_RM;
  logic [ptsre_pkg::COUNT_W-1:0]   count_q = 3'd1;
  logic [31:0]                     word_q [ptsre_pkg::MAX_TASKS] = '{default: '0};
  logic [15:0]                     release_cnt [ptsre_pkg::MAX_TASKS] = '{default: '0};
  logic [15:0]                     work_cnt [ptsre_pkg::MAX_TASKS] = '{default: '0};
  logic [15:0]                     now_cnt = '0;

  sched_out_t tick_results_due [$];
  int         mismatch_count = 0;
  int         burst_left = 0;
  bit         hold_now = 1'b0;

  // Directed ticks and register writes, walked in order
  dir_row_t directed_rows [DIR_ROWS] = '{
    '{ROW_TICK,  ptsre_pkg::REG_MODE,  32'h0,         1'b0, 1'b1, '{1'b0, 2'd0, 1'b0, 16'd0}},
    '{ROW_TICK,  ptsre_pkg::REG_MODE,  32'h0,         1'b0, 1'b1, '{1'b0, 2'd0, 1'b0, 16'd1}},
    '{ROW_WRITE, ptsre_pkg::REG_TASK0, 32'h0003_0002, 1'b0, 1'b0, NO_WANT},
    '{ROW_TICK,  ptsre_pkg::REG_MODE,  32'h0,         1'b1, 1'b1, '{1'b1, 2'd0, 1'b0, 16'd0}},
    '{ROW_TICK,  ptsre_pkg::REG_MODE,  32'h0,         1'b0, 1'b1, '{1'b1, 2'd0, 1'b0, 16'd1}},
    '{ROW_TICK,  ptsre_pkg::REG_MODE,  32'h0,         1'b0, 1'b1, '{1'b0, 2'd0, 1'b0, 16'd2}},
    '{ROW_WRITE, ptsre_pkg::REG_TASK0, 32'h0002_0003, 1'b0, 1'b0, NO_WANT},
    '{ROW_TICK,  ptsre_pkg::REG_MODE,  32'h0,         1'b0, 1'b1, '{1'b1, 2'd0, 1'b0, 16'd3}},
    '{ROW_TICK,  ptsre_pkg::REG_MODE,  32'h0,         1'b0, 1'b1, '{1'b1, 2'd0, 1'b1, 16'd4}},
    '{ROW_TICK,  ptsre_pkg::REG_MODE,  32'h0,         1'b0, 1'b1, '{1'b1, 2'd0, 1'b0, 16'd5}},
    '{ROW_WRITE, ptsre_pkg::REG_COUNT, 32'h0000_0004, 1'b0, 1'b0, NO_WANT},
    '{ROW_WRITE, REG_TASK1,            32'h0000_0001, 1'b0, 1'b0, NO_WANT},
    '{ROW_WRITE, REG_TASK2,            32'hFFFF_FFFF, 1'b0, 1'b0, NO_WANT},
    '{ROW_WRITE, REG_TASK3,            32'h0005_0000, 1'b0, 1'b0, NO_WANT},
    '{ROW_TICK,  ptsre_pkg::REG_MODE,  32'h0,         1'b1, 1'b0, NO_WANT},
    '{ROW_TICK,  ptsre_pkg::REG_MODE,  32'h0,         1'b0, 1'b0, NO_WANT},
    '{ROW_TICK,  ptsre_pkg::REG_MODE,  32'h0,         1'b0, 1'b0, NO_WANT},
    '{ROW_WRITE, ptsre_pkg::REG_MODE,  32'h0000_0001, 1'b0, 1'b0, NO_WANT},
    '{ROW_TICK,  ptsre_pkg::REG_MODE,  32'h0,         1'b0, 1'b0, NO_WANT},
    '{ROW_TICK,  ptsre_pkg::REG_MODE,  32'h0,         1'b0, 1'b0, NO_WANT},
    '{ROW_WRITE, ptsre_pkg::REG_COUNT, 32'h0000_0000, 1'b0, 1'b0, NO_WANT},
    '{ROW_TICK,  ptsre_pkg::REG_MODE,  32'h0,         1'b0, 1'b0, NO_WANT},
    '{ROW_WRITE, ptsre_pkg::REG_COUNT, 32'h0000_0007, 1'b0, 1'b0, NO_WANT},
    '{ROW_TICK,  ptsre_pkg::REG_MODE,  32'h0,         1'b0, 1'b0, NO_WANT},
    '{ROW_TICK,  ptsre_pkg::REG_MODE,  32'h0,         1'b0, 1'b0, NO_WANT},
    '{ROW_WRITE, REG_SPARE,            32'hFFFF_FFFF, 1'b0, 1'b0, NO_WANT},
    '{ROW_WRITE, ptsre_pkg::REG_TASK0, 32'hFFFF_FFFF, 1'b0, 1'b0, NO_WANT},
    '{ROW_TICK,  ptsre_pkg::REG_MODE,  32'h0,         1'b0, 1'b0, NO_WANT},
    '{ROW_TICK,  ptsre_pkg::REG_MODE,  32'h0,         1'b1, 1'b0, NO_WANT}
  };

  periodic_task_scheduler_rm_edf_core u_top (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .restart         (restart),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .busy_res        (busy_res),
    .running_task    (running_task),
    .deadline_missed (deadline_missed),
    .tick_time       (tick_time)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #(RUN_LIMIT_NS);
    $display("** periodic_task_scheduler_rm_edf_core: FAILED **");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < PRINT_CAP)
      $display("%0t mismatch: %s got 0x%0h want 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Advance the scheduler image by one tick and return its result beat
  function automatic sched_out_t schedule_tick(input logic rs);
    int          used;
    bit          found;
    int          best;
    logic [15:0] best_key;
    logic [15:0] key;
    logic [15:0] per;
    sched_out_t  r;
    used = (count_q > ptsre_pkg::MAX_TASKS) ? ptsre_pkg::MAX_TASKS : int'(count_q);
    found = 1'b0;
    best = 0;
    best_key = '0;
    r = '0;
    if (rs) begin
      now_cnt = '0;
      for (int i = 0; i < ptsre_pkg::MAX_TASKS; i++) release_cnt[i] = '0;
    end
    for (int i = 0; i < ptsre_pkg::MAX_TASKS; i++) begin
      per = (word_q[i][31:16] == '0) ? 16'd1 : word_q[i][31:16];
      if (i >= used) begin
        release_cnt[i] = '0;
        work_cnt[i] = '0;
      end else begin
        if (release_cnt[i] == '0) begin
          work_cnt[i] = word_q[i][15:0];
          release_cnt[i] = per;
        end
        if (work_cnt[i] != '0) begin
          key = (mode_q == ptsre_pkg::MODE_EDF) ? release_cnt[i] : per;
          if (!found || key < best_key) begin
            found = 1'b1;
            best = i;
            best_key = key;
          end
        end
      end
    end
    if (found) begin
      work_cnt[best] = work_cnt[best] - 16'd1;
      r.busy = 1'b1;
      r.slot = best[1:0];
      r.missed = (work_cnt[best] != '0) && (release_cnt[best] == 16'd1);
    end
    r.stamp = now_cnt;
    for (int i = 0; i < used; i++) release_cnt[i] = release_cnt[i] - 16'd1;
    now_cnt = now_cnt + 16'd1;
    return r;
  endfunction

  function automatic void store_reg(input logic [ptsre_pkg::REG_IDX_W-1:0] idx,
                                    input logic [31:0] val);
    case (idx)
      ptsre_pkg::REG_MODE:  mode_q = val[0];
      ptsre_pkg::REG_COUNT: count_q = val[ptsre_pkg::COUNT_W-1:0];
      default: begin
        if (idx >= ptsre_pkg::REG_TASK0 && idx <= REG_TASK3)
          word_q[2'(idx - ptsre_pkg::REG_TASK0)] = val;
      end
    endcase
  endfunction

  function automatic logic [31:0] reg_value(input logic [ptsre_pkg::REG_IDX_W-1:0] idx);
    case (idx)
      ptsre_pkg::REG_MODE:  return {31'b0, mode_q};
      ptsre_pkg::REG_COUNT: return {{(32-ptsre_pkg::COUNT_W){1'b0}}, count_q};
      default:              return word_q[2'(idx - ptsre_pkg::REG_TASK0)];
    endcase
  endfunction

  // Mostly short periods and small work, with the odd extreme
  function automatic logic [31:0] random_task_word();
    logic [15:0] per;
    logic [15:0] ex;
    case ($urandom_range(0, 15))
      0:       per = '0;
      1:       per = 16'hFFFF;
      2:       per = 16'($urandom);
      default: per = 16'($urandom_range(1, 20));
    endcase
    case ($urandom_range(0, 15))
      0:       ex = '0;
      1:       ex = 16'hFFFF;
      2:       ex = 16'($urandom);
      default: ex = 16'($urandom_range(1, 6));
    endcase
    return {per, ex};
  endfunction

  // APB write, then read back the same register
  task automatic write_reg(input logic [ptsre_pkg::REG_IDX_W-1:0] idx,
                           input logic [31:0] val);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    store_reg(idx, val);
    @(negedge clk);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if (idx <= REG_TASK3 && prdata !== reg_value(idx))
      report_mismatch("register readback", prdata, reg_value(idx));
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  // Drop valid and wait for every result to come back
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (tick_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Offer one tick beat, with bursts and gaps on the sender side
  task automatic offer_tick(input logic rs, input logic typed, input sched_out_t want);
    sched_out_t guess;
    int         gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        restart = 1'($urandom_range(0, 1));
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    restart = rs;
    do @(posedge clk); while (in_stall);
    guess = schedule_tick(rs);
    tick_results_due.push_back(typed ? want : guess);
  endtask

  // Receiver stall pattern, plus one long hold-off on request
  initial begin : stall_gen
    int mode_left;
    int stall_mode;
    mode_left = 0;
    stall_mode = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_now) begin
        out_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        hold_now = 1'b0;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(8, 60);
      end
      mode_left--;
      if (stall_mode == 0)
        out_stall = 1'b0;
      else if (stall_mode == 1)
        out_stall = ($urandom_range(0, 3) == 0);
      else
        out_stall = ($urandom_range(0, 3) != 0);
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin : result_check
    sched_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (tick_results_due.size() == 0) begin
        report_mismatch("result with nothing expected", 32'(tick_time), 32'd0);
      end else begin
        want = tick_results_due.pop_front();
        if (busy_res !== want.busy)
          report_mismatch("busy_res", 32'(busy_res), 32'(want.busy));
        if (running_task !== want.slot)
          report_mismatch("running_task", 32'(running_task), 32'(want.slot));
        if (deadline_missed !== want.missed)
          report_mismatch("deadline_missed", 32'(deadline_missed), 32'(want.missed));
        if (tick_time !== want.stamp)
          report_mismatch("tick_time", 32'(tick_time), 32'(want.stamp));
      end
    end
  end

  initial begin : stimulus
    logic                            mode_pick;
    logic [ptsre_pkg::COUNT_W-1:0]   count_pick;
    logic [31:0]                     words [ptsre_pkg::MAX_TASKS];
    int                              len;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    restart = 1'b0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // Directed table
    foreach (directed_rows[k]) begin
      if (directed_rows[k].kind == ROW_WRITE) begin
        settle();
        write_reg(directed_rows[k].idx, directed_rows[k].data);
      end else begin
        offer_tick(directed_rows[k].rs, directed_rows[k].typed, directed_rows[k].want);
      end
    end

    // Random phases; the receiver holds off once while the first phase runs
    for (int p = 0; p < RAND_PHASES; p++) begin
      settle();
      if (p == 0) begin
        mode_pick = ptsre_pkg::MODE_RM;
        count_pick = 3'd4;
        words[0] = 32'h0001_FFFF;
        words[1] = 32'hFFFF_0001;
        words[2] = 32'h0000_0000;
        words[3] = 32'hFFFF_FFFF;
      end else begin
        mode_pick = (p == RAND_PHASES - 1) ? ptsre_pkg::MODE_EDF :
                    1'($urandom_range(0, 1));
        if (p == RAND_PHASES - 1) count_pick = 3'd4;
        else if ($urandom_range(0, 3) == 0) count_pick = 3'($urandom_range(0, 7));
        else count_pick = 3'($urandom_range(1, 4));
        foreach (words[j]) words[j] = random_task_word();
      end
      write_reg(ptsre_pkg::REG_MODE, {31'b0, mode_pick});
      write_reg(ptsre_pkg::REG_COUNT, {{(32-ptsre_pkg::COUNT_W){1'b0}}, count_pick});
      foreach (words[j])
        write_reg(ptsre_pkg::REG_TASK0 + ptsre_pkg::REG_IDX_W'(j), words[j]);
      if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, $urandom);
      if (p == 0) hold_now = 1'b1;
      len = $urandom_range(100, 150);
      for (int n = 0; n < len; n++)
        offer_tick((n == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 49) == 0),
                   1'b0, NO_WANT);
    end

    settle();
    if (mismatch_count == 0) begin
      $display("** periodic_task_scheduler_rm_edf_core: PASSED **");
    end else begin
      $display("** periodic_task_scheduler_rm_edf_core: FAILED **");
    end
    $finish;
  end

endmodule
